/* src/rqmt_pkg.sv */
// Shared constants, types and index helpers for the ring queue with max tracking.
package rqmt_pkg;

    localparam int unsigned QUEUE_DEPTH = 64;
    localparam int unsigned IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int unsigned ID_W        = 27;
    localparam int unsigned GRADE_W     = 10;
    localparam int unsigned ENTRY_W     = 7;
    localparam int unsigned STATUS_W    = 2;

    localparam int unsigned IN_DATA_W   = 40;
    localparam int unsigned OUT_DATA_W  = 56;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic               flag;
        logic [GRADE_W-1:0] grade;
    } rec_t;

    typedef enum logic {
        ACT_PUSH = 1'b0,
        ACT_POP  = 1'b1
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EXEC = 5'b00010,
        ST_HEAD = 5'b00100,
        ST_SCAN = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        if (i == IDX_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = i + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] tail_index(input logic [IDX_W-1:0] head,
                                                    input logic [CNT_W-1:0] count);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + (IDX_W+1)'(count);
        if (sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
            sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

/* src/ring_queue_with_max_tracking.sv */
// Top level: circular record queue with running maximum grade.
// A push or refused request passes through the execute and emit states; a pop
// also reads the head record, and when the popped record held the maximum it
// rescans the remaining records one by one over the store's single read port.
// One transaction at a time; a finished result may wait in the output register.
// Reset (aresetn low, synchronous) empties the queue and clears the maximum.
module ring_queue_with_max_tracking import rqmt_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // student_id[26:0], has_grade[27], grade[37:28], zero[39:38]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // action[0]
    input  logic [0:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // max_grade[9:0], entry_count[16:10], popped_id[43:17],
    // popped_has_grade[44], popped_grade[54:45], zero[55]
    output logic [OUT_DATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [STATUS_W-1:0]   m_tuser
);

    state_t                state_reg, state_next;
    action_t               act_reg, act_next;
    rec_t                  in_rec_reg, in_rec_next;
    logic [IDX_W-1:0]      head_reg, head_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [GRADE_W-1:0]    max_reg, max_next;
    status_t               res_status_reg, res_status_next;
    rec_t                  res_pop_reg, res_pop_next;
    logic [IDX_W-1:0]      scan_addr_reg, scan_addr_next;
    logic [CNT_W-1:0]      scan_left_reg, scan_left_next;
    logic [GRADE_W-1:0]    best_reg, best_next;
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic [STATUS_W-1:0]   m_user_reg, m_user_next;

    logic                  ram_we;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;
    rec_t                  ram_rdata;
    logic [GRADE_W-1:0]    cand;

    rqmt_store u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (tail_index(head_reg, count_reg)),
        .wdata (in_rec_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cand = (ram_rdata.flag && (ram_rdata.grade > best_reg)) ? ram_rdata.grade : best_reg;

    always_comb begin
        state_next      = state_reg;
        act_next        = act_reg;
        in_rec_next     = in_rec_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        max_next        = max_reg;
        res_status_next = res_status_reg;
        res_pop_next    = res_pop_reg;
        scan_addr_next  = scan_addr_reg;
        scan_left_next  = scan_left_reg;
        best_next       = best_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = head_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    act_next          = action_t'(s_tuser[0]);
                    in_rec_next.id    = s_tdata[26:0];
                    in_rec_next.flag  = s_tdata[27];
                    in_rec_next.grade = s_tdata[27] ? s_tdata[37:28] : '0;
                    state_next        = ST_EXEC;
                end
            end
            ST_EXEC: begin
                res_pop_next    = '0;
                res_status_next = STAT_DONE;
                if (act_reg == ACT_PUSH) begin
                    if (count_reg == CNT_W'(QUEUE_DEPTH)) begin
                        res_status_next = STAT_FULL;
                    end else begin
                        ram_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                        if (in_rec_reg.flag && (in_rec_reg.grade > max_reg)) begin
                            max_next = in_rec_reg.grade;
                        end
                    end
                    state_next = ST_EMIT;
                end else if (count_reg == '0) begin
                    res_status_next = STAT_EMPTY;
                    state_next      = ST_EMIT;
                end else begin
                    ram_re     = 1'b1;
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD: begin
                res_pop_next = ram_rdata;
                head_next    = wrap_inc(head_reg);
                count_next   = count_reg - 1'b1;
                state_next   = ST_EMIT;
                if (ram_rdata.flag && (ram_rdata.grade == max_reg)) begin
                    best_next = '0;
                    if (count_reg == CNT_W'(1)) begin
                        max_next = '0;
                    end else begin
                        ram_re         = 1'b1;
                        ram_raddr      = wrap_inc(head_reg);
                        scan_addr_next = wrap_inc(head_reg);
                        scan_left_next = count_reg - 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_left_reg == CNT_W'(1)) begin
                    max_next   = cand;
                    state_next = ST_EMIT;
                end else begin
                    best_next      = cand;
                    ram_re         = 1'b1;
                    ram_raddr      = wrap_inc(scan_addr_reg);
                    scan_addr_next = wrap_inc(scan_addr_reg);
                    scan_left_next = scan_left_reg - 1'b1;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_user_next  = res_status_reg;
                    m_data_next  = {1'b0, res_pop_reg.grade, res_pop_reg.flag,
                                    res_pop_reg.id, ENTRY_W'(count_reg), max_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            max_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            max_reg     <= max_next;
            m_valid_reg <= m_valid_next;
        end
        act_reg        <= act_next;
        in_rec_reg     <= in_rec_next;
        res_status_reg <= res_status_next;
        res_pop_reg    <= res_pop_next;
        scan_addr_reg  <= scan_addr_next;
        scan_left_reg  <= scan_left_next;
        best_reg       <= best_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

/* src/rqmt_store.sv */
// Record store: one write port, one read port with registered read data.
module rqmt_store import rqmt_pkg::*; (
    input  logic             aclk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  rec_t             wdata,
    input  logic             re,
    input  logic [IDX_W-1:0] raddr,
    output rec_t             rdata
);

    rec_t mem [QUEUE_DEPTH];
    rec_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the ring queue with running maximum grade.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rqmt_pkg::*;

    localparam int NUM_DIRECTED = 20;
    localparam int RANDOM_ITEMS = 1830;
    localparam int CALM_TAIL    = 200;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        status_t            status;
        logic [GRADE_W-1:0] max_grade;
        logic [ENTRY_W-1:0] entry_count;
        logic [ID_W-1:0]    popped_id;
        logic               popped_has_grade;
        logic [GRADE_W-1:0] popped_grade;
    } outcome_t;

    typedef struct packed {
        action_t            act;
        logic [ID_W-1:0]    id;
        logic               flag;
        logic [GRADE_W-1:0] grade;
        logic               typed;
        outcome_t           want;
    } stim_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    // shadow of the queue contents and running maximum
    rec_t               shelf [QUEUE_DEPTH];
    int unsigned        shelf_head;
    int unsigned        shelf_count;
    logic [GRADE_W-1:0] top_grade;

    outcome_t pending_outcomes [$];

    int  mismatches;
    int  results_seen;
    int  items_sent;
    int  refused_full;
    int  refused_empty;
    int  rescans;
    int  deepest;
    bit  gaps_on;
    bit  stalls_on;

    stim_row_t directed_plan [0:NUM_DIRECTED-1] = '{
        '{ACT_POP,  27'd0,        1'b0, 10'd0,    1'b1,
          '{STAT_EMPTY, 10'd0,    7'd0, 27'd0,        1'b0, 10'd0}},
        '{ACT_PUSH, 27'h7FFFFFF,  1'b1, 10'd1023, 1'b1,
          '{STAT_DONE,  10'd1023, 7'd1, 27'd0,        1'b0, 10'd0}},
        '{ACT_PUSH, 27'd0,        1'b0, 10'd1023, 1'b1,
          '{STAT_DONE,  10'd1023, 7'd2, 27'd0,        1'b0, 10'd0}},
        '{ACT_PUSH, 27'd12345,    1'b1, 10'd0,    1'b1,
          '{STAT_DONE,  10'd1023, 7'd3, 27'd0,        1'b0, 10'd0}},
        '{ACT_POP,  27'h5555555,  1'b1, 10'd777,  1'b1,
          '{STAT_DONE,  10'd0,    7'd2, 27'h7FFFFFF,  1'b1, 10'd1023}},
        '{ACT_POP,  27'd0,        1'b0, 10'd0,    1'b1,
          '{STAT_DONE,  10'd0,    7'd1, 27'd0,        1'b0, 10'd0}},
        '{ACT_POP,  27'd0,        1'b0, 10'd0,    1'b1,
          '{STAT_DONE,  10'd0,    7'd0, 27'd12345,    1'b1, 10'd0}},
        '{ACT_POP,  27'h7FFFFFF,  1'b1, 10'd1023, 1'b1,
          '{STAT_EMPTY, 10'd0,    7'd0, 27'd0,        1'b0, 10'd0}},
        '{ACT_PUSH, 27'd99999999, 1'b1, 10'd1000, 1'b0, '0},
        '{ACT_PUSH, 27'd1,        1'b1, 10'd500,  1'b0, '0},
        '{ACT_PUSH, 27'd2,        1'b1, 10'd1000, 1'b0, '0},
        '{ACT_PUSH, 27'd3,        1'b0, 10'd0,    1'b0, '0},
        '{ACT_PUSH, 27'd4,        1'b1, 10'd999,  1'b0, '0},
        '{ACT_POP,  27'd0,        1'b0, 10'd0,    1'b0, '0},
        '{ACT_POP,  27'd0,        1'b0, 10'd0,    1'b0, '0},
        '{ACT_POP,  27'd0,        1'b0, 10'd0,    1'b0, '0},
        '{ACT_PUSH, 27'd5,        1'b1, 10'd1,    1'b0, '0},
        '{ACT_POP,  27'd0,        1'b0, 10'd0,    1'b0, '0},
        '{ACT_POP,  27'd0,        1'b0, 10'd0,    1'b0, '0},
        '{ACT_POP,  27'd0,        1'b0, 10'd0,    1'b0, '0}
    };

    ring_queue_with_max_tracking i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #15_000_000;
        $display("Timeout: %0d items sent, %0d results seen", items_sent, results_seen);
        $display("Test completed with failures");
        $finish;
    end

    function automatic outcome_t queue_step(action_t act, logic [ID_W-1:0] id, logic flag,
                                            logic [GRADE_W-1:0] grade);
        outcome_t           res;
        rec_t               rec;
        logic [GRADE_W-1:0] best;
        res = '0;
        res.status = STAT_DONE;
        if (act == ACT_PUSH) begin
            if (shelf_count >= QUEUE_DEPTH) begin
                res.status = STAT_FULL;
                refused_full++;
            end else begin
                rec.id    = id;
                rec.flag  = flag;
                rec.grade = flag ? grade : '0;
                shelf[(shelf_head + shelf_count) % QUEUE_DEPTH] = rec;
                shelf_count++;
                if (flag && rec.grade > top_grade)
                    top_grade = rec.grade;
            end
        end else begin
            if (shelf_count == 0) begin
                res.status = STAT_EMPTY;
                refused_empty++;
            end else begin
                rec = shelf[shelf_head];
                res.popped_id        = rec.id;
                res.popped_has_grade = rec.flag;
                res.popped_grade     = rec.grade;
                shelf_head  = (shelf_head + 1) % QUEUE_DEPTH;
                shelf_count--;
                if (rec.flag && rec.grade == top_grade) begin
                    rescans++;
                    deepest = (shelf_count > deepest) ? shelf_count : deepest;
                    best = '0;
                    for (int k = 0; k < shelf_count; k++) begin
                        if (shelf[(shelf_head + k) % QUEUE_DEPTH].flag &&
                            shelf[(shelf_head + k) % QUEUE_DEPTH].grade > best)
                            best = shelf[(shelf_head + k) % QUEUE_DEPTH].grade;
                    end
                    top_grade = best;
                end
            end
        end
        res.max_grade   = top_grade;
        res.entry_count = ENTRY_W'(shelf_count);
        return res;
    endfunction

    function automatic logic [GRADE_W-1:0] random_grade();
        logic [GRADE_W-1:0] g;
        case ($urandom_range(0, 9))
            0:       g = 10'd1000;
            1:       g = GRADE_W'($urandom_range(1001, 1023));
            2:       g = GRADE_W'(500 + 100 * $urandom_range(0, 3));
            default: g = GRADE_W'($urandom_range(0, 1000));
        endcase
        return g;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("MISMATCH result %0d %s: got %0d expected %0d",
                 results_seen, field, got, want);
        mismatches++;
    endtask

    task automatic send_item(action_t act, logic [ID_W-1:0] id, logic flag,
                             logic [GRADE_W-1:0] grade, logic typed, outcome_t typed_res);
        outcome_t res;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = act;
        s_tdata  = {2'b00, grade, flag, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        res = queue_step(act, id, flag, grade);
        pending_outcomes.push_back(typed ? typed_res : res);
        items_sent++;
        @(negedge aclk);
    endtask

    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (stalls_on && $urandom_range(0, 4) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge aclk);
            end
            m_tready = 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_outcomes.size() == 0) begin
                $display("MISMATCH result %0d arrived with nothing expected", results_seen);
                mismatches++;
            end else begin
                want = pending_outcomes.pop_front();
                if (m_tuser != want.status)
                    report_mismatch("status", m_tuser, want.status);
                if (m_tdata[9:0] != want.max_grade)
                    report_mismatch("max_grade", m_tdata[9:0], want.max_grade);
                if (m_tdata[16:10] != want.entry_count)
                    report_mismatch("entry_count", m_tdata[16:10], want.entry_count);
                if (m_tdata[43:17] != want.popped_id)
                    report_mismatch("popped_id", m_tdata[43:17], want.popped_id);
                if (m_tdata[44] != want.popped_has_grade)
                    report_mismatch("popped_has_grade", m_tdata[44], want.popped_has_grade);
                if (m_tdata[54:45] != want.popped_grade)
                    report_mismatch("popped_grade", m_tdata[54:45], want.popped_grade);
                if (m_tdata[55] != 1'b0)
                    report_mismatch("tdata padding", m_tdata[55], 0);
            end
        end
    end

    initial begin
        int                 random_sent;
        int                 phase_len;
        int                 push_pct;
        action_t            act;
        logic [ID_W-1:0]    id;
        logic               flag;
        logic [GRADE_W-1:0] grade;

        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        shelf_head  = 0;
        shelf_count = 0;
        top_grade   = '0;
        mismatches  = 0;
        gaps_on     = 1'b1;
        stalls_on   = 1'b1;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (directed_plan[i])
            send_item(directed_plan[i].act, directed_plan[i].id, directed_plan[i].flag,
                      directed_plan[i].grade, directed_plan[i].typed, directed_plan[i].want);

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            phase_len = $urandom_range(20, 120);
            case ($urandom_range(0, 2))
                0:       push_pct = 85;
                1:       push_pct = 50;
                default: push_pct = 15;
            endcase
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            if (random_sent >= RANDOM_ITEMS - CALM_TAIL) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            for (int n = 0; n < phase_len && random_sent < RANDOM_ITEMS; n++) begin
                act   = ($urandom_range(1, 100) <= push_pct) ? ACT_PUSH : ACT_POP;
                id    = ($urandom_range(0, 3) == 0) ? ID_W'($urandom())
                                                    : ID_W'($urandom_range(0, 99999999));
                flag  = ($urandom_range(0, 3) != 0);
                grade = random_grade();
                send_item(act, id, flag, grade, 1'b0, '0);
                random_sent++;
            end
        end
        s_tvalid = 1'b0;

        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d transactions, checked %0d results, %0d mismatches",
                 items_sent, results_seen, mismatches);
        $display("Refused: %0d full, %0d empty; %0d maximum rescans, deepest over %0d records",
                 refused_full, refused_empty, rescans, deepest);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
